[hw/rtl/csvp_pkg.sv]
package csvp_pkg;

  // Largest column count the schema can describe.
  localparam int unsigned MaxColumnsDef = 64;

  // Result queue depth, a power of two with room for two words per item.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = QueuePtrW + 1;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CountW   = 7;
  localparam int unsigned ColW     = 6;
  localparam int unsigned OutDataW = 216;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COLUMN_COUNT = 2'd0,
    REG_TYPES_LOW    = 2'd1,
    REG_TYPES_HIGH   = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CT_INT = 2'd0,
    CT_DEC = 2'd1,
    CT_STR = 2'd2
  } col_type_e;

  typedef enum logic [2:0] {
    KIND_INT      = 3'd0,
    KIND_DEC      = 3'd1,
    KIND_STR_BYTE = 3'd2,
    KIND_STR_END  = 3'd3,
    KIND_ROLLBACK = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ColW-1:0]    column;
    logic signed [63:0] int_value;
    logic [63:0]        whole_part;
    logic [63:0]        fraction_part;
    logic               is_negative;
    logic [7:0]         string_byte;
    logic [ColW-1:0]    drop_count;
    logic               last_result;
  } result_t;

  // Which of the two result slots the parser pushes in a cycle.
  typedef struct packed {
    logic valid_a;
    logic valid_b;
  } push_t;

  // The unused type code reads as a string column.
  function automatic col_type_e decode_type(input logic [1:0] raw);
    col_type_e t;
    t = (raw == 2'd3) ? CT_STR : col_type_e'(raw);
    return t;
  endfunction

endpackage

[hw/rtl/csvp_parser.sv]
module csvp_parser #(
  parameter int unsigned MAX_COLUMNS = csvp_pkg::MaxColumnsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [csvp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csvp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_byte_i,
  input  logic                           in_first_i,
  input  logic                           in_last_i,
  input  logic                           room_i,
  output csvp_pkg::push_t                push_o,
  output csvp_pkg::result_t              res_a_o,
  output csvp_pkg::result_t              res_b_o
);

  localparam logic [csvp_pkg::CountW-1:0] MaxCnt = csvp_pkg::CountW'(MAX_COLUMNS);

  // Configuration registers.
  logic [csvp_pkg::CountW-1:0] count_q;
  logic [63:0]                 types_lo_q, types_hi_q;

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       first_q, last_q;

  // Parser state.
  logic                      skip_q, skip_d;
  logic [csvp_pkg::ColW-1:0] col_q, col_d;
  logic                      started_q, started_d;
  logic                      sign_q, sign_d;
  logic                      frac_q, frac_d;
  logic [63:0]               wacc_q, wacc_d;
  logic [63:0]               facc_q, facc_d;

  logic                      skip_c, started_c, sign_c, frac_c;
  logic [csvp_pkg::ColW-1:0] col_c;
  logic [63:0]               wacc_c, facc_c, digit;
  logic [csvp_pkg::CountW-1:0] eff_cnt, col_inc;
  logic                      consume, accept, is_delim;
  logic [1:0]                raw_type;
  csvp_pkg::col_type_e       ctype;
  csvp_pkg::result_t         r0, r1;
  logic                      r0_valid, r1_valid;

  assign consume    = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (consume) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= csvp_pkg::CountW'(1);
      types_lo_q <= '0;
      types_hi_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        csvp_pkg::REG_COLUMN_COUNT: count_q    <= cfg_wdata_i[csvp_pkg::CountW-1:0];
        csvp_pkg::REG_TYPES_LOW:    types_lo_q <= cfg_wdata_i;
        csvp_pkg::REG_TYPES_HIGH:   types_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= in_byte_i;
      first_q <= in_first_i;
      last_q  <= in_last_i;
    end
  end

  always_comb begin
    eff_cnt = count_q;
    if (eff_cnt == '0) begin
      eff_cnt = csvp_pkg::CountW'(1);
    end else if (eff_cnt > MaxCnt) begin
      eff_cnt = MaxCnt;
    end
  end

  always_comb begin
    // A first-of-chunk mark clears the row state and enters line-skipping mode before the word is handled.
    skip_c    = first_q ? 1'b1 : skip_q;
    col_c     = first_q ? '0 : col_q;
    started_c = first_q ? 1'b0 : started_q;
    sign_c    = first_q ? 1'b0 : sign_q;
    frac_c    = first_q ? 1'b0 : frac_q;
    wacc_c    = first_q ? '0 : wacc_q;
    facc_c    = first_q ? '0 : facc_q;

    skip_d    = skip_c;
    col_d     = col_c;
    started_d = started_c;
    sign_d    = sign_c;
    frac_d    = frac_c;
    wacc_d    = wacc_c;
    facc_d    = facc_c;

    raw_type = col_c[5] ? types_hi_q[{col_c[4:0], 1'b0} +: 2]
                        : types_lo_q[{col_c[4:0], 1'b0} +: 2];
    ctype    = csvp_pkg::decode_type(raw_type);
    digit    = {56'd0, byte_q} - 64'(csvp_pkg::CH_ZERO);
    col_inc  = {1'b0, col_c} + csvp_pkg::CountW'(1);
    is_delim = (byte_q == csvp_pkg::CH_COMMA) || (byte_q == csvp_pkg::CH_NEWLINE);

    r0       = '0;
    r1       = '0;
    r0_valid = 1'b0;
    r1_valid = 1'b0;
    r0.column = col_c;

    if (skip_c) begin
      if (byte_q == csvp_pkg::CH_NEWLINE) begin
        skip_d = 1'b0;
      end
    end else if (is_delim) begin
      r0_valid = 1'b1;
      case (ctype)
        csvp_pkg::CT_INT: begin
          r0.kind      = csvp_pkg::KIND_INT;
          r0.int_value = sign_c ? (64'd0 - wacc_c) : wacc_c;
        end
        csvp_pkg::CT_DEC: begin
          r0.kind          = csvp_pkg::KIND_DEC;
          r0.whole_part    = wacc_c;
          r0.fraction_part = facc_c;
          r0.is_negative   = sign_c;
        end
        default: begin
          r0.kind = csvp_pkg::KIND_STR_END;
        end
      endcase
      started_d = 1'b0;
      sign_d    = 1'b0;
      frac_d    = 1'b0;
      wacc_d    = '0;
      facc_d    = '0;
      col_d     = (col_inc >= eff_cnt) ? '0 : col_inc[csvp_pkg::ColW-1:0];
    end else begin
      // A byte that comes with the chunk end only marks the field as begun.
      if (!last_q) begin
        if (ctype == csvp_pkg::CT_STR) begin
          r0_valid       = 1'b1;
          r0.kind        = csvp_pkg::KIND_STR_BYTE;
          r0.string_byte = byte_q;
        end else if (!started_c && byte_q == csvp_pkg::CH_MINUS) begin
          sign_d = 1'b1;
        end else if (ctype == csvp_pkg::CT_DEC && !frac_c && byte_q == csvp_pkg::CH_POINT) begin
          frac_d = 1'b1;
        end else if (ctype == csvp_pkg::CT_DEC && frac_c) begin
          facc_d = (facc_c << 3) + (facc_c << 1) + digit;
        end else begin
          wacc_d = (wacc_c << 3) + (wacc_c << 1) + digit;
        end
      end
      started_d = 1'b1;
    end

    if (last_q) begin
      if (!skip_c && (col_d != '0 || started_d)) begin
        r1_valid      = 1'b1;
        r1.kind       = csvp_pkg::KIND_ROLLBACK;
        r1.column     = col_d;
        r1.drop_count = col_d;
      end
      skip_d    = 1'b1;
      col_d     = '0;
      started_d = 1'b0;
      sign_d    = 1'b0;
      frac_d    = 1'b0;
      wacc_d    = '0;
      facc_d    = '0;
    end

    // Pack the results into the first free slots; the last one is flagged.
    if (r0_valid) begin
      res_a_o = r0;
      res_b_o = r1;
      res_a_o.last_result = !r1_valid;
      res_b_o.last_result = 1'b1;
    end else begin
      res_a_o = r1;
      res_b_o = r1;
      res_a_o.last_result = 1'b1;
    end
    push_o.valid_a = consume && (r0_valid || r1_valid);
    push_o.valid_b = consume && r0_valid && r1_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      skip_q     <= 1'b1;
      col_q      <= '0;
      started_q  <= 1'b0;
      sign_q     <= 1'b0;
      frac_q     <= 1'b0;
      wacc_q     <= '0;
      facc_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (consume) begin
        skip_q    <= skip_d;
        col_q     <= col_d;
        started_q <= started_d;
        sign_q    <= sign_d;
        frac_q    <= frac_d;
        wacc_q    <= wacc_d;
        facc_q    <= facc_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_second_is_rollback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid_b |-> (res_b_o.kind == csvp_pkg::KIND_ROLLBACK && res_b_o.last_result))
    else $error("second result of a word is not a rollback");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(consume) |-> ({1'b0, col_q} < MaxCnt))
    else $error("column index beyond the column limit");
`endif

endmodule

[hw/rtl/csvp_result_fifo.sv]
module csvp_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csvp_pkg::push_t    push_i,
  input  csvp_pkg::result_t  res_a_i,
  input  csvp_pkg::result_t  res_b_i,
  output logic               room_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output csvp_pkg::result_t  out_res_o
);

  localparam int unsigned Depth = csvp_pkg::QueueDepth;
  localparam int unsigned PtrW  = csvp_pkg::QueuePtrW;
  localparam int unsigned CntW  = csvp_pkg::QueueCntW;

  csvp_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              pop;

  assign out_valid_o = (count_q != '0);
  assign out_res_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for two words, the most one item can give.
  assign room_o      = (count_q <= CntW'(Depth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.valid_a) + PtrW'(push_i.valid_b);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_i.valid_a) + CntW'(push_i.valid_b) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid_a) begin
      mem_q[wr_ptr_q] <= res_a_i;
    end
    if (push_i.valid_b) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= res_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid_a |-> (count_q <= CntW'(Depth - 2)))
    else $error("result pushed without room for two words");

  a_b_needs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid_b |-> push_i.valid_a)
    else $error("second slot pushed without the first");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");
`endif

endmodule

[hw/rtl/typed_csv_field_parser.sv]
// Typed CSV field parser.
// The slave stream carries CSV text one byte per word; tuser marks the first
// byte of a chunk and tlast its final byte. The master stream carries typed
// results: tuser is the result kind and tlast flags the final result caused
// by one input byte. The user must write the column count and the 2-bit
// column types on the plain write port only while the block is idle; the
// block itself does not enforce this. A byte accepted into the input
// register is parsed there, and its results are written into the result
// queue, which drives the master stream.
// Throughput: one byte per cycle while the result queue has room for two
// entries. The master side delivers one result per cycle while tready is
// high, so a delimiter that closes a chunk (up to two results) needs an
// extra output slot, absorbed by the four-entry result queue.
// Reset clears the queue, restores column count one and all-integer types,
// and starts in line-skipping mode. When the receiver stalls, results wait
// in the queue; once fewer than two entries are free, the input register
// holds its byte and tready drops after it has filled.
module typed_csv_field_parser #(
  parameter int unsigned MAX_COLUMNS = csvp_pkg::MaxColumnsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [csvp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [csvp_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] text_byte
  input  logic                            s_axis_tuser_i,  // [0] chunk_first
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [5:0] column, [69:6] int_value, [133:70] whole_part,
  // [197:134] fraction_part, [198] is_negative, [206:199] string_byte,
  // [212:207] drop_count, [215:213] zero
  output logic [csvp_pkg::OutDataW-1:0]   m_axis_tdata_o,
  output logic [2:0]                      m_axis_tuser_o,  // [2:0] kind
  output logic                            m_axis_tlast_o
);

  csvp_pkg::push_t   push;
  csvp_pkg::result_t res_a, res_b, head;
  logic              room;

  csvp_parser #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_first_i (s_axis_tuser_i),
    .in_last_i  (s_axis_tlast_i),
    .room_i     (room),
    .push_o     (push),
    .res_a_o    (res_a),
    .res_b_o    (res_b)
  );

  csvp_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .res_a_i    (res_a),
    .res_b_i    (res_b),
    .room_o     (room),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .out_res_o  (head)
  );

  assign m_axis_tdata_o = {3'b000, head.drop_count, head.string_byte, head.is_negative,
                           head.fraction_part, head.whole_part, head.int_value,
                           head.column};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last_result;

endmodule
